// File: rtl/steq_pkg.sv
// package for the sorted timer event queue: types, codes and constants
package steq_pkg;
	localparam int unsigned ENTRIES_DEFAULT = 16;
	localparam int unsigned TIME_W = 64;
	localparam int unsigned TAG_W = 32;
	localparam int unsigned HANDLE_W = 4;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_TICK   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTQUEUED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		TA_LEAVE = 2'd0,
		TA_LOAD  = 2'd1,
		TA_CLEAR = 2'd2,
		TA_RSVD  = 2'd3
	} tact_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_WR,
		S_INS_LNK,
		S_POP_RD,
		S_POP_NXT,
		S_POP_DL,
		S_REM_RD,
		S_REM_CMP,
		S_REM_FIX
	} fsm_t;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [TIME_W-1:0]   event_time;
		logic [TAG_W-1:0]    payload_tag;
		logic [HANDLE_W-1:0] slot_handle;
	} cmd_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] new_handle;
		logic                fired;
		logic [TAG_W-1:0]    fired_tag;
		logic [1:0]          timer_action;
		logic [TIME_W-1:0]   timer_value;
	} res_t;
endpackage

// File: rtl/steq_cmd_if.sv
// valid/ready channel interface for command and result words
interface steq_cmd_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/steq_ram.sv
// generic single port write, single read port ram with registered read
module steq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/sorted_timer_event_queue.sv
// top level of the sorted timer event queue
//
//  channel | dir | word    | fields
//  cmd     | in  | cmd_t   | opcode, event_time, payload_tag, slot_handle
//  res     | out | res_t   | status, new_handle, fired, fired_tag, timer_action, timer_value
//
// one command at a time; the result word is valid after the last busy cycle and the
// next command is taken in the cycle after that word leaves
// insert: pool check and head read, a compare of each entry walked, the write and a
// relink of the predecessor when the new entry is not the head; tick and head remove:
// head read, its tag and link, then the new head's deadline, skipped when the queue
// empties; other removes walk to the predecessor and fix its link; full, empty and
// unqueued cases end in the first state; every list step waits on the registered read
// of the link memory; reset clears the count, queued bits and armed flag and fills the
// free ring; a stalled result holds in the output register and holds off the next command
module sorted_timer_event_queue
	import steq_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
	input logic           clk,
	input logic           arst_n,
	steq_cmd_if.sink      cmd,
	steq_cmd_if.source    res
);
	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned EW = TIME_W + TAG_W;

	fsm_t state_q, state_d;

	// command latch
	cmd_t cmd_q;

	// control state
	logic [ENTRIES-1:0] queued_q;
	logic [IW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic               armed_q;
	// free ring of slot numbers, flops since ENTRIES is small
	logic [IW-1:0]      ring_q [ENTRIES];
	logic [IW-1:0]      frd_q;
	logic [CW-1:0]      fcnt_q;

	// walk state
	logic [IW-1:0]      cur_q, prev_q, slot_q;
	logic               has_prev_q;
	logic [CW-1:0]      idx_q;
	logic [TAG_W-1:0]   tag_q;

	res_t               res_q;
	logic               rvalid_q;

	// memories: deadline and tag share one entry, links in their own
	logic               ent_we, lk_we;
	logic [IW-1:0]      ent_wa, ent_ra, lk_wa, lk_ra;
	logic [EW-1:0]      ent_wd, ent_rd;
	logic [IW-1:0]      lk_wd, lk_rd;
	logic [TIME_W-1:0]  rd_time;
	logic [TAG_W-1:0]   rd_tag;

	assign ent_wa  = slot_q;
	assign ent_wd  = {cmd_q.event_time, cmd_q.payload_tag};
	assign rd_time = ent_rd[EW-1:TAG_W];
	assign rd_tag  = ent_rd[TAG_W-1:0];

	steq_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry (
		.clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(ent_ra),
		.rdata(ent_rd));
	steq_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_link (
		.clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));

	assign cmd.ready = (state_q == S_IDLE) && !rvalid_q;
	assign res.valid = rvalid_q;
	assign res.data  = res_q;

	logic cmd_fire;
	assign cmd_fire = cmd.valid && cmd.ready;

	// handle in range and queued
	logic [HANDLE_W+IW-1:0] h_wide;
	logic [IW-1:0]          h_idx;
	logic                   h_ok;
	always_comb begin
		h_wide = {{IW{1'b0}}, cmd_q.slot_handle};
		h_idx = h_wide[IW-1:0];
		h_ok = (h_wide < (HANDLE_W+IW)'(ENTRIES)) && queued_q[h_idx];
	end

	// slot number as a handle
	logic [HANDLE_W+IW-1:0] s_wide;
	assign s_wide = {{HANDLE_W{1'b0}}, slot_q};

	logic is_tick;
	assign is_tick = (opcode_t'(cmd_q.opcode) == OP_TICK);

	// datapath control
	logic           fin;
	res_t           res_d;
	logic           walk_adv;
	logic           rel;
	logic [IW-1:0]  rel_slot;

	always_comb begin
		state_d = state_q;
		ent_we = 1'b0; ent_ra = cur_q;
		lk_we = 1'b0; lk_wa = slot_q; lk_wd = cur_q; lk_ra = cur_q;
		fin = 1'b0;
		res_d = '0;
		walk_adv = 1'b0;
		rel = 1'b0;
		rel_slot = head_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					case (opcode_t'(cmd.data.opcode))
						OP_INSERT: state_d = S_INS_RD;
						OP_TICK:   state_d = S_POP_RD;
						OP_REMOVE: state_d = S_REM_RD;
						default:   fin = 1'b1;
					endcase
				end
			end
			S_INS_RD: begin
				// read of the head is issued here when the list is not empty
				if (fcnt_q == '0) begin
					res_d.status = ST_FULL;
					fin = 1'b1;
				end else if (idx_q == count_q) begin
					state_d = S_INS_WR;
				end else begin
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				// equal deadlines are passed so arrival order holds
				if (rd_time > cmd_q.event_time) begin
					state_d = S_INS_WR;
				end else begin
					walk_adv = 1'b1;
					if ((CW+1)'(idx_q) + (CW+1)'(1) == (CW+1)'(count_q)) begin
						state_d = S_INS_WR;
					end else begin
						ent_ra = lk_rd;
						lk_ra = lk_rd;
					end
				end
			end
			S_INS_WR: begin
				ent_we = 1'b1;
				lk_we = 1'b1;
				lk_wa = slot_q;
				lk_wd = (idx_q < count_q) ? cur_q : '0;
				if (has_prev_q) begin
					state_d = S_INS_LNK;
				end else begin
					res_d.new_handle = s_wide[HANDLE_W-1:0];
					res_d.timer_action = TA_LOAD;
					res_d.timer_value = cmd_q.event_time;
					fin = 1'b1;
				end
			end
			S_INS_LNK: begin
				lk_we = 1'b1;
				lk_wa = prev_q;
				lk_wd = slot_q;
				res_d.new_handle = s_wide[HANDLE_W-1:0];
				fin = 1'b1;
			end
			S_POP_RD: begin
				if (count_q == '0) begin
					if (armed_q) res_d.status = ST_EMPTY;
					fin = 1'b1;
				end else begin
					ent_ra = head_q;
					lk_ra = head_q;
					state_d = S_POP_NXT;
				end
			end
			S_POP_NXT: begin
				// tag and link of the old head are valid now
				res_d.fired = is_tick;
				res_d.fired_tag = is_tick ? rd_tag : '0;
				if (count_q == CW'(1)) begin
					res_d.timer_action = TA_CLEAR;
					rel = 1'b1;
					fin = 1'b1;
				end else begin
					ent_ra = lk_rd;
					state_d = S_POP_DL;
				end
			end
			S_POP_DL: begin
				// deadline of the new head reprograms the compare
				res_d.fired = is_tick;
				res_d.fired_tag = is_tick ? tag_q : '0;
				res_d.timer_action = TA_LOAD;
				res_d.timer_value = rd_time;
				rel = 1'b1;
				fin = 1'b1;
			end
			S_REM_RD: begin
				if (!h_ok) begin
					res_d.status = ST_NOTQUEUED;
					fin = 1'b1;
				end else if (head_q == h_idx) begin
					ent_ra = head_q;
					lk_ra = head_q;
					state_d = S_POP_NXT;
				end else begin
					lk_ra = cur_q;
					state_d = S_REM_CMP;
				end
			end
			S_REM_CMP: begin
				// lk_rd is the successor of cur_q
				if (lk_rd == h_idx) begin
					lk_ra = h_idx;
					state_d = S_REM_FIX;
				end else if ((CW+1)'(idx_q) + (CW+1)'(2) >= (CW+1)'(count_q)) begin
					rel = 1'b1;
					rel_slot = h_idx;
					fin = 1'b1;
				end else begin
					walk_adv = 1'b1;
					lk_ra = lk_rd;
				end
			end
			S_REM_FIX: begin
				lk_we = 1'b1;
				lk_wa = cur_q;
				lk_wd = lk_rd;
				rel = 1'b1;
				rel_slot = h_idx;
				fin = 1'b1;
			end
			default: state_d = S_IDLE;
		endcase
		if (fin) state_d = S_IDLE;
	end

	// ring position behind the last free slot
	logic [CW:0]    wsum;
	logic [IW-1:0]  wpos;
	always_comb begin
		wsum = (CW+1)'(frd_q) + (CW+1)'(fcnt_q);
		if (wsum >= (CW+1)'(ENTRIES)) wsum = wsum - (CW+1)'(ENTRIES);
		wpos = wsum[IW-1:0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			queued_q <= '0;
			head_q <= '0;
			count_q <= '0;
			armed_q <= 1'b0;
			frd_q <= '0;
			fcnt_q <= CW'(ENTRIES);
			for (int i = 0; i < ENTRIES; i++) ring_q[i] <= IW'(i);
			rvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) begin
				rvalid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				rvalid_q <= 1'b0;
			end
			if (state_q == S_INS_WR) begin
				queued_q[slot_q] <= 1'b1;
				count_q <= count_q + 1'b1;
				frd_q <= (frd_q == IW'(ENTRIES - 1)) ? '0 : frd_q + 1'b1;
				fcnt_q <= fcnt_q - 1'b1;
				if (!has_prev_q) begin
					head_q <= slot_q;
					armed_q <= 1'b1;
				end
			end
			if (state_q == S_POP_NXT && count_q == CW'(1)) begin
				head_q <= '0;
				armed_q <= 1'b0;
			end
			if (state_q == S_POP_DL) begin
				head_q <= cur_q;
				armed_q <= 1'b1;
			end
			// released slot joins the back of the free ring
			if (rel) begin
				queued_q[rel_slot] <= 1'b0;
				count_q <= count_q - 1'b1;
				fcnt_q <= fcnt_q + 1'b1;
				ring_q[wpos] <= rel_slot;
			end
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_q <= cmd.data;
			cur_q <= head_q;
			prev_q <= '0;
			idx_q <= '0;
			has_prev_q <= 1'b0;
			slot_q <= ring_q[frd_q];
		end
		if (walk_adv) begin
			prev_q <= cur_q;
			has_prev_q <= 1'b1;
			cur_q <= lk_rd;
			idx_q <= idx_q + 1'b1;
		end
		if (state_q == S_POP_NXT) begin
			tag_q <= rd_tag;
			cur_q <= lk_rd;
		end
		if (fin) begin
			res_q <= res_d;
		end
	end
endmodule

// File: rtl/steq_checker.sv
// port level checks of the sorted timer event queue, bound to the top level
module steq_checker
	import steq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res_data
);
	// a result never shows a reserved timer action
	a_act: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.timer_action != TA_RSVD) else $error("reserved action");
	// a fired result always loads or clears the compare register
	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.fired |-> res_data.timer_action != TA_LEAVE)
		else $error("fire without timer action");
	// no new command while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !cmd_ready) else $error("ready with pending result");
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data)) else $error("result dropped");
endmodule

bind sorted_timer_event_queue steq_checker u_steq_checker (
	.clk(clk), .arst_n(arst_n),
	.cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
	.res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);
